@@ hw/rtl/gycl_pkg.sv @@
// ----------------------------------------------------------------------------
// Gimbal yaw cascade loop package
// Shared widths, fixed-point constants, register codes, types and state
// encodings for the yaw cascade loop.
// ----------------------------------------------------------------------------
package gycl_pkg;

    // Encoder resolution; the degree scaling below assumes a power of two.
    localparam int ENCODER_COUNTS = 8192;
    localparam int ENC_SHIFT      = $clog2(ENCODER_COUNTS);

    localparam int ENC_W   = 13;
    localparam int DATA_W  = 32;
    localparam int DRIVE_W = 14;
    localparam int LIMIT_W = 13;
    localparam int ACC_W   = 64;
    localparam int MAG_W   = 62;
    localparam int PROD_W  = 64;
    localparam int DEG_W   = ENC_W + 27;
    localparam int PADDR_W = 4;

    localparam logic [LIMIT_W-1:0] CENTER_CAP = LIMIT_W'(1500);
    localparam logic [LIMIT_W-1:0] WORK_LIMIT = LIMIT_W'(4500);

    // Q16.16 constants, rounded to nearest.
    localparam logic signed [DATA_W-1:0] AUTO_OFFSET   = DATA_W'(244449);
    localparam logic [DATA_W-1:0]        AUTO_POS_GAIN = DATA_W'(537395);
    localparam logic [DATA_W-1:0]        AUTO_VEL_GAIN = DATA_W'(3604480);

    // Degrees per full turn in Q16.16.
    localparam logic [DEG_W-1:0] DEG_SCALE = DEG_W'(360 * 65536);

    // Multiply operands and products saturate at +-2^61.
    localparam logic [MAG_W-1:0]        SAT_MAG = {1'b1, {(MAG_W-1){1'b0}}};
    localparam logic signed [ACC_W-1:0] SAT_POS = $signed({2'b00, SAT_MAG});
    localparam logic signed [ACC_W-1:0] SAT_NEG = -SAT_POS;

    localparam logic [DATA_W-1:0] GAIN_RESET = DATA_W'(65536);

    typedef enum logic [1:0] {
        REG_ENC_CENTER = 2'd0,
        REG_POS_GAIN   = 2'd1,
        REG_VEL_GAIN   = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic [ENC_W-1:0]  encoder_center;
        logic [DATA_W-1:0] position_gain;
        logic [DATA_W-1:0] velocity_gain;
    } t_cfg;

    typedef struct packed {
        logic                      start;
        logic signed [ACC_W-1:0]   a;
        logic [DATA_W-1:0]         g;
    } t_qmul_req;

    typedef struct packed {
        logic             done;
        logic             neg;
        logic [MAG_W-1:0] mag;
    } t_qmul_rsp;

    typedef enum logic [1:0] {
        Q_IDLE,
        Q_LO,
        Q_HI,
        Q_SUM
    } t_qmul_state;

    typedef enum logic [3:0] {
        S_IDLE,
        S_OP1,
        S_MUL1,
        S_WAIT1,
        S_SUM,
        S_MUL2,
        S_WAIT2,
        S_OUT
    } t_seq_state;

endpackage

@@ hw/rtl/gycl_in_if.sv @@
// ----------------------------------------------------------------------------
// Yaw loop input channel
// Valid/ready channel that carries one control tick's sensor item.
// ----------------------------------------------------------------------------
interface gycl_in_if;
    logic                                valid;
    logic                                ready;
    logic                                working;
    logic                                auto_aim;
    logic [gycl_pkg::ENC_W-1:0]          encoder_count;
    logic signed [gycl_pkg::DATA_W-1:0]  gyro_rate;
    logic signed [gycl_pkg::DATA_W-1:0]  yaw_angle;
    logic signed [gycl_pkg::DATA_W-1:0]  setpoint;
    logic signed [gycl_pkg::DATA_W-1:0]  vision_yaw;

    modport source (
        output valid, working, auto_aim, encoder_count, gyro_rate,
               yaw_angle, setpoint, vision_yaw,
        input  ready
    );

    modport sink (
        input  valid, working, auto_aim, encoder_count, gyro_rate,
               yaw_angle, setpoint, vision_yaw,
        output ready
    );
endinterface

@@ hw/rtl/gycl_out_if.sv @@
// ----------------------------------------------------------------------------
// Yaw loop output channel
// Valid/ready channel that carries the drive command and updated setpoint.
// ----------------------------------------------------------------------------
interface gycl_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [gycl_pkg::DRIVE_W-1:0] drive;
    logic signed [gycl_pkg::DATA_W-1:0]  setpoint_out;

    modport source (
        output valid, drive, setpoint_out,
        input  ready
    );

    modport sink (
        input  valid, drive, setpoint_out,
        output ready
    );
endinterface

@@ hw/rtl/gycl_cfg.sv @@
// ----------------------------------------------------------------------------
// Yaw loop configuration registers
// APB-style register file holding the encoder center and the two loop gains.
// ----------------------------------------------------------------------------
module gycl_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [gycl_pkg::PADDR_W-1:0]   paddr,
    input  logic [gycl_pkg::DATA_W-1:0]    pwdata,
    output logic [gycl_pkg::DATA_W-1:0]    prdata,
    output logic                           pready,
    output gycl_pkg::t_cfg                 o_cfg
);
    import gycl_pkg::*;

    t_cfg     r_cfg;
    t_cfg     n_cfg;
    logic     wr_en;
    t_reg_idx reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = t_reg_idx'(paddr[PADDR_W-1:2]);

    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            case (reg_idx)
                REG_ENC_CENTER: n_cfg.encoder_center = pwdata[ENC_W-1:0];
                REG_POS_GAIN:   n_cfg.position_gain  = pwdata;
                REG_VEL_GAIN:   n_cfg.velocity_gain  = pwdata;
                default:        n_cfg = r_cfg;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_ENC_CENTER: prdata = DATA_W'(r_cfg.encoder_center);
            REG_POS_GAIN:   prdata = r_cfg.position_gain;
            REG_VEL_GAIN:   prdata = r_cfg.velocity_gain;
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.encoder_center <= '0;
            r_cfg.position_gain  <= GAIN_RESET;
            r_cfg.velocity_gain  <= GAIN_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ hw/rtl/gycl_qmul.sv @@
// ----------------------------------------------------------------------------
// Yaw loop Q16.16 multiply unit
// Saturating sign-magnitude multiply of a value by an unsigned gain, built
// from two passes through one 32x32 multiplier.
// ----------------------------------------------------------------------------
module gycl_qmul (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  gycl_pkg::t_qmul_req   i_req,
    output gycl_pkg::t_qmul_rsp   o_rsp
);
    import gycl_pkg::*;

    t_qmul_state          r_state;
    t_qmul_state          n_state;
    logic [MAG_W-1:0]     r_m;
    logic [MAG_W-1:0]     n_m;
    logic                 r_neg;
    logic                 n_neg;
    logic [DATA_W-1:0]    r_g;
    logic [DATA_W-1:0]    n_g;
    logic [PROD_W-1:0]    r_lo;
    logic [PROD_W-1:0]    r_hi;
    logic [MAG_W-1:0]     r_mag;
    logic                 r_done;
    logic [DATA_W-1:0]    mul_x;
    logic [PROD_W-1:0]    mul_p;
    logic [ACC_W-1:0]     a_abs;
    logic                 a_over;
    logic [MAG_W:0]       sum_s;
    logic [MAG_W-1:0]     sum_mag;

    assign a_over = ($signed(i_req.a) > SAT_POS) || ($signed(i_req.a) < SAT_NEG);
    assign a_abs  = i_req.a[ACC_W-1] ? ACC_W'(-i_req.a) : ACC_W'(i_req.a);

    // Low word of the magnitude first, then the upper 30 bits.
    assign mul_x = (r_state == Q_LO) ? r_m[DATA_W-1:0]
                                     : DATA_W'(r_m[MAG_W-1:DATA_W]);
    assign mul_p = PROD_W'(mul_x) * PROD_W'(r_g);

    assign sum_s = {2'b00, r_hi[44:0], 16'b0} + {15'b0, r_lo[PROD_W-1:16]};

    always_comb begin
        if ((r_hi[PROD_W-1:45] != '0) || (sum_s > {1'b0, SAT_MAG})) begin
            sum_mag = SAT_MAG;
        end else begin
            sum_mag = sum_s[MAG_W-1:0];
        end
    end

    always_comb begin
        n_state = r_state;
        n_m     = r_m;
        n_neg   = r_neg;
        n_g     = r_g;
        case (r_state)
            Q_IDLE: begin
                if (i_req.start) begin
                    n_m     = a_over ? SAT_MAG : a_abs[MAG_W-1:0];
                    n_neg   = i_req.a[ACC_W-1];
                    n_g     = i_req.g;
                    n_state = Q_LO;
                end
            end
            Q_LO:    n_state = Q_HI;
            Q_HI:    n_state = Q_SUM;
            Q_SUM:   n_state = Q_IDLE;
            default: n_state = Q_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= Q_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == Q_SUM);
        end
    end

    always_ff @(posedge i_clk) begin
        r_m   <= n_m;
        r_neg <= n_neg;
        r_g   <= n_g;
        if (r_state == Q_LO) begin
            r_lo <= mul_p;
        end
        if (r_state == Q_HI) begin
            r_hi <= mul_p;
        end
        if (r_state == Q_SUM) begin
            r_mag <= sum_mag;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.neg  = r_neg;
    assign o_rsp.mag  = r_mag;

endmodule

@@ hw/rtl/gimbal_yaw_cascade_loop.sv @@
// ----------------------------------------------------------------------------
// Gimbal yaw cascade loop
// Position and velocity proportional stages for the yaw axis, one control
// tick per input item, with current limit ramp and output clamp.
// ----------------------------------------------------------------------------
// Each accepted item yields exactly one result item, loaded into the output
// register from S_OUT once both products are done. The edge that loads it
// returns the sequencer to idle, so the input is ready again while that
// result waits; no new item is taken before the previous result is loaded.
// The work is two chained Q16.16 products (position stage, then velocity
// stage), each made of two partial products on the one shared 32x32
// multiplier plus a combine step. If the previous result is still waiting
// in the output register when the next one is finished, the sequencer holds
// in its last state until the receiver takes it. The current limit is
// updated when an item is accepted; configuration registers may be written
// at any time the block is idle and apply to the next item.
module gimbal_yaw_cascade_loop (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    gycl_in_if.sink                       i_item,
    gycl_out_if.source                    o_result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [gycl_pkg::PADDR_W-1:0]  paddr,
    input  logic [gycl_pkg::DATA_W-1:0]   pwdata,
    output logic [gycl_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);
    import gycl_pkg::*;

    t_cfg       cfg;
    t_qmul_req  qreq;
    t_qmul_rsp  qrsp;

    t_seq_state                 r_state;
    t_seq_state                 n_state;
    logic [LIMIT_W-1:0]         r_limit;
    logic [LIMIT_W-1:0]         n_limit;
    logic                       r_out_valid;
    logic                       n_out_valid;

    logic                       r_normal;
    logic                       r_auto;
    logic [ENC_W-1:0]           r_enc;
    logic signed [DATA_W-1:0]   r_gyro;
    logic signed [DATA_W-1:0]   r_angle;
    logic signed [DATA_W-1:0]   r_sp;
    logic signed [DATA_W-1:0]   r_vis;
    logic signed [ACC_W-1:0]    r_opa;
    logic signed [ACC_W-1:0]    n_opa;
    logic [DATA_W-1:0]          r_gain;
    logic [DATA_W-1:0]          n_gain;
    logic signed [ACC_W-1:0]    r_pos;
    logic signed [ACC_W-1:0]    n_pos;
    logic [LIMIT_W-1:0]         r_dmag;
    logic [LIMIT_W-1:0]         n_dmag;
    logic                       r_dneg;
    logic                       n_dneg;
    logic signed [DRIVE_W-1:0]  r_drive;
    logic signed [DATA_W-1:0]   r_sp_out;

    logic                       accept;
    logic                       load_out;
    logic                       auto_mode;
    logic                       manual_mode;
    logic                       pos_negate;
    logic                       vel_negate;
    logic [LIMIT_W-1:0]         limit_inc;
    logic signed [ENC_W:0]      enc_delta;
    logic [ENC_W-1:0]           enc_mag;
    logic [DEG_W-1:0]           deg_prod;
    logic [DEG_W-1:0]           deg_mag;
    logic signed [ACC_W-1:0]    deg_val;
    logic signed [ACC_W-1:0]    op1_val;
    logic signed [ACC_W-1:0]    mag_signed;

    gycl_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    gycl_qmul u_qmul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (qreq),
        .o_rsp   (qrsp)
    );

    assign i_item.ready = (r_state == S_IDLE);
    assign accept       = i_item.valid && (r_state == S_IDLE);
    assign load_out     = (r_state == S_OUT) && (!r_out_valid || o_result.ready);

    assign auto_mode   = r_normal && r_auto;
    assign manual_mode = r_normal && !r_auto;
    // Centering and manual negate the position product; centering and auto
    // negate the velocity product.
    assign pos_negate  = !auto_mode;
    assign vel_negate  = !manual_mode;

    assign limit_inc = r_limit + LIMIT_W'(1);

    // Encoder offset scaled to Q16.16 degrees, truncated toward zero.
    assign enc_delta = $signed({1'b0, r_enc}) - $signed({1'b0, cfg.encoder_center});
    assign enc_mag   = enc_delta[ENC_W] ? ENC_W'(-enc_delta) : enc_delta[ENC_W-1:0];
    assign deg_prod  = DEG_W'(enc_mag) * DEG_SCALE;
    assign deg_mag   = deg_prod >> ENC_SHIFT;
    assign deg_val   = enc_delta[ENC_W] ? -$signed(ACC_W'(deg_mag))
                                        : $signed(ACC_W'(deg_mag));

    always_comb begin
        if (!r_normal) begin
            op1_val = deg_val;
        end else if (!r_auto) begin
            op1_val = ACC_W'(r_sp) + ACC_W'(r_angle);
        end else if (r_vis == '0) begin
            // No vision target: zero position demand.
            op1_val = '0;
        end else begin
            op1_val = ACC_W'(r_vis) - ACC_W'(AUTO_OFFSET);
        end
    end

    assign mag_signed = $signed({2'b00, qrsp.mag});

    assign qreq.start = (r_state == S_MUL1) || (r_state == S_MUL2);
    assign qreq.a     = r_opa;
    assign qreq.g     = r_gain;

    always_comb begin
        n_state     = r_state;
        n_limit     = r_limit;
        n_opa       = r_opa;
        n_gain      = r_gain;
        n_pos       = r_pos;
        n_dmag      = r_dmag;
        n_dneg      = r_dneg;
        n_out_valid = r_out_valid;
        if (r_out_valid && o_result.ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (!i_item.working) begin
                        n_limit = (limit_inc > CENTER_CAP) ? CENTER_CAP : limit_inc;
                    end else begin
                        n_limit = WORK_LIMIT;
                    end
                    n_state = S_OP1;
                end
            end
            S_OP1: begin
                n_opa   = op1_val;
                n_gain  = auto_mode ? AUTO_POS_GAIN : cfg.position_gain;
                n_state = S_MUL1;
            end
            S_MUL1: n_state = S_WAIT1;
            S_WAIT1: begin
                if (qrsp.done) begin
                    n_pos   = (qrsp.neg ^ pos_negate) ? -mag_signed : mag_signed;
                    n_state = S_SUM;
                end
            end
            S_SUM: begin
                n_opa   = manual_mode ? (r_pos - ACC_W'(r_gyro))
                                      : (r_pos + ACC_W'(r_gyro));
                n_gain  = auto_mode ? AUTO_VEL_GAIN : cfg.velocity_gain;
                n_state = S_MUL2;
            end
            S_MUL2: n_state = S_WAIT2;
            S_WAIT2: begin
                if (qrsp.done) begin
                    // Clamp to the limit, then drop the fraction.
                    if (qrsp.mag >= MAG_W'({r_limit, 16'b0})) begin
                        n_dmag = r_limit;
                    end else begin
                        n_dmag = qrsp.mag[LIMIT_W+15:16];
                    end
                    n_dneg  = qrsp.neg ^ vel_negate;
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (load_out) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_limit     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_limit     <= n_limit;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_normal <= i_item.working;
            r_auto   <= i_item.auto_aim;
            r_enc    <= i_item.encoder_count;
            r_gyro   <= i_item.gyro_rate;
            r_angle  <= i_item.yaw_angle;
            r_sp     <= i_item.setpoint;
            r_vis    <= i_item.vision_yaw;
        end
        r_opa  <= n_opa;
        r_gain <= n_gain;
        r_pos  <= n_pos;
        r_dmag <= n_dmag;
        r_dneg <= n_dneg;
        if (load_out) begin
            r_drive  <= r_dneg ? DRIVE_W'(-{1'b0, r_dmag}) : DRIVE_W'({1'b0, r_dmag});
            r_sp_out <= auto_mode ? -r_angle : r_sp;
        end
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.drive        = r_drive;
    assign o_result.setpoint_out = r_sp_out;

endmodule
